// File: sv/tmps_pkg.sv
// Shared types, constants and pattern tables for the motion pattern sequencer.
package tmps_pkg;

	localparam int CFG_W = 31;

	localparam logic [1:0] REG_PATTERN = 2'd0;
	localparam logic [1:0] REG_MOVE    = 2'd1;
	localparam logic [1:0] REG_PAUSE   = 2'd2;
	localparam logic [1:0] REG_SETTLE  = 2'd3;

	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic PAT_SQUARE  = 1'b0;
	localparam logic PAT_HEXAGON = 1'b1;

	localparam logic [3:0] SQUARE_STEPS = 4'd8;
	localparam logic [3:0] HEX_STEPS    = 4'd14;

	localparam logic [7:0] MV_OFF   = 8'h00;
	localparam logic [7:0] MV_FWD   = 8'h55;
	localparam logic [7:0] MV_BACK  = 8'hAA;
	localparam logic [7:0] MV_RIGHT = 8'h96;
	localparam logic [7:0] MV_LEFT  = 8'h69;
	localparam logic [7:0] MV_NE    = 8'h14;
	localparam logic [7:0] MV_SE    = 8'h82;
	localparam logic [7:0] MV_SW    = 8'h28;
	localparam logic [7:0] MV_NW    = 8'h41;
	localparam logic [7:0] MV_ROT   = 8'h99;

	typedef enum logic [4:0] {
		PH_LATCH  = 5'b00001,
		PH_MOVE   = 5'b00010,
		PH_PAUSE  = 5'b00100,
		PH_SETTLE = 5'b01000,
		PH_FINISH = 5'b10000
	} phase_t;

	typedef struct packed {
		logic             pattern_select;
		logic [CFG_W-1:0] move_time;
		logic [CFG_W-1:0] pause_time;
		logic [CFG_W-1:0] settle_time;
	} cfg_t;

	typedef struct packed {
		logic [7:0] drive;
		logic       drive_written;
		logic       step_done;
		logic [3:0] step_number;
		logic [2:0] phase_number;
	} result_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_LATCH:  code = 3'd0;
			PH_MOVE:   code = 3'd1;
			PH_PAUSE:  code = 3'd2;
			PH_SETTLE: code = 3'd3;
			PH_FINISH: code = 3'd4;
			default:   code = 3'd0;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] square_drive(input logic [2:0] idx);
		logic [7:0] d;
		case (idx)
			3'd0:    d = MV_FWD;
			3'd2:    d = MV_RIGHT;
			3'd4:    d = MV_BACK;
			3'd6:    d = MV_LEFT;
			default: d = MV_ROT;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] hex_drive(input logic [3:0] idx);
		logic [7:0] d;
		case (idx)
			4'd0:    d = MV_NW;
			4'd2:    d = MV_FWD;
			4'd4:    d = MV_NE;
			4'd6:    d = MV_RIGHT;
			4'd8:    d = MV_SE;
			4'd10:   d = MV_BACK;
			4'd12:   d = MV_SW;
			default: d = MV_ROT;
		endcase
		return d;
	endfunction

endpackage

// File: sv/tmps_core.sv
// Step and phase state with the per-word next-state and result logic.
module tmps_core #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic                   op,
	input  logic [TIME_BITS-1:0]   now,
	input  tmps_pkg::cfg_t         cfg,
	output tmps_pkg::result_t      res
);

	localparam int CMP_W = (TIME_BITS > tmps_pkg::CFG_W) ? TIME_BITS : tmps_pkg::CFG_W;

	logic [3:0]           step_q;
	tmps_pkg::phase_t     phase_q;
	logic [TIME_BITS-1:0] start_q;
	logic [7:0]           drive_q;

	logic [3:0]           step_d;
	tmps_pkg::phase_t     phase_d;
	logic [TIME_BITS-1:0] start_d;
	logic [7:0]           drive_d;
	logic                 written;
	logic                 done;
	logic [3:0]           count;
	logic [3:0]           step_inc;
	logic [TIME_BITS-1:0] delta;
	logic [CMP_W-1:0]     elapsed;
	logic [7:0]           table_drive;

	assign count    = (cfg.pattern_select == tmps_pkg::PAT_HEXAGON) ?
		tmps_pkg::HEX_STEPS : tmps_pkg::SQUARE_STEPS;
	assign step_inc = step_q + 4'd1;
	assign delta    = now - start_q;
	assign elapsed  = CMP_W'(delta);
	assign table_drive = (cfg.pattern_select == tmps_pkg::PAT_HEXAGON) ?
		tmps_pkg::hex_drive(step_q) : tmps_pkg::square_drive(step_q[2:0]);

	always_comb begin
		step_d  = step_q;
		phase_d = phase_q;
		start_d = start_q;
		drive_d = drive_q;
		written = 1'b0;
		done    = 1'b0;
		if (op == tmps_pkg::OP_RESTART) begin
			step_d  = 4'd0;
			phase_d = tmps_pkg::PH_LATCH;
			start_d = '0;
		end else if (step_q < count) begin
			case (phase_q)
				tmps_pkg::PH_LATCH: begin
					drive_d = table_drive;
					start_d = now;
					phase_d = tmps_pkg::PH_MOVE;
					written = 1'b1;
				end
				tmps_pkg::PH_MOVE: begin
					if (elapsed >= CMP_W'(cfg.move_time)) begin
						drive_d = tmps_pkg::MV_OFF;
						start_d = now;
						phase_d = tmps_pkg::PH_PAUSE;
						written = 1'b1;
					end
				end
				tmps_pkg::PH_PAUSE: begin
					if (elapsed >= CMP_W'(cfg.pause_time)) begin
						start_d = now;
						phase_d = tmps_pkg::PH_SETTLE;
					end
				end
				tmps_pkg::PH_SETTLE: begin
					if (elapsed >= CMP_W'(cfg.settle_time)) begin
						phase_d = tmps_pkg::PH_FINISH;
					end
				end
				tmps_pkg::PH_FINISH: begin
					phase_d = tmps_pkg::PH_LATCH;
					done    = 1'b1;
					step_d  = (step_inc >= count) ? 4'd0 : step_inc;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 4'd0;
			phase_q <= tmps_pkg::PH_LATCH;
			start_q <= '0;
			drive_q <= tmps_pkg::MV_OFF;
		end else if (fire) begin
			step_q  <= step_d;
			phase_q <= phase_d;
			start_q <= start_d;
			drive_q <= drive_d;
		end
	end

	assign res.drive         = drive_d;
	assign res.drive_written = written;
	assign res.step_done     = done;
	assign res.step_number   = step_d;
	assign res.phase_number  = tmps_pkg::phase_code(phase_d);

endmodule

// File: sv/timed_motion_pattern_sequencer.sv
// Top level: input register, configuration registers, core and result register.
//
//   channel | signals                                   | role
//   in      | in_valid in_ready op now_ms               | restart or time sample word
//   out     | out_valid out_ready wheel1..4_dir,         | drive and progress word
//           | drive_written step_done step_number       |
//           | phase_number                              |
//   cfg     | cfg_we cfg_index cfg_data                 | register write, no wait
//
// One word per cycle while the result is not stalled; an accepted word passes through the
// input register, then the state update into the result register.
// arst_n clears step, phase, start time, drive, the configuration and both valid flags.
// A stalled result holds the input register; a new word is still taken
// while the input register empties into the result register.
module timed_motion_pattern_sequencer #(
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [31:0]                 now_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  wheel1_dir,
	output logic [1:0]                  wheel2_dir,
	output logic [1:0]                  wheel3_dir,
	output logic [1:0]                  wheel4_dir,
	output logic                        drive_written,
	output logic                        step_done,
	output logic [3:0]                  step_number,
	output logic [2:0]                  phase_number,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [tmps_pkg::CFG_W-1:0]  cfg_data
);

	tmps_pkg::cfg_t       cfg_q;
	logic                 valid_s1;
	logic                 op_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 out_valid_q;
	tmps_pkg::result_t    res_q;
	tmps_pkg::result_t    res_d;
	logic                 advance;
	logic                 fire;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tmps_pkg::REG_PATTERN: cfg_q.pattern_select <= cfg_data[0];
				tmps_pkg::REG_MOVE:    cfg_q.move_time      <= cfg_data;
				tmps_pkg::REG_PAUSE:   cfg_q.pause_time     <= cfg_data;
				tmps_pkg::REG_SETTLE:  cfg_q.settle_time    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			now_s1 <= TIME_BITS'(now_ms);
		end
	end

	tmps_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.now    (now_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign wheel1_dir    = res_q.drive[1:0];
	assign wheel2_dir    = res_q.drive[3:2];
	assign wheel3_dir    = res_q.drive[5:4];
	assign wheel4_dir    = res_q.drive[7:6];
	assign drive_written = res_q.drive_written;
	assign step_done     = res_q.step_done;
	assign step_number   = res_q.step_number;
	assign phase_number  = res_q.phase_number;

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == tmps_pkg::OP_RESTART) |=>
		(out_valid && step_number == 4'd0 && phase_number == 3'd0
		&& !drive_written && !step_done))
		else $error("restart did not clear step and phase");

	a_stop_wheels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_written && phase_number == 3'd2) |->
		(wheel1_dir == 2'd0 && wheel2_dir == 2'd0 && wheel3_dir == 2'd0
		&& wheel4_dir == 2'd0))
		else $error("wheels still driven after move phase");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_done) |-> (phase_number == 3'd0 && !drive_written))
		else $error("step completion without return to first phase");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (step_number < tmps_pkg::HEX_STEPS && phase_number <= 3'd4))
		else $error("step or phase out of range");

endmodule

// File: sim/tmps_status_checker.sv
// Status checker for the motion pattern sequencer: predicts each result word and compares it.
module tmps_status_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       op,
	input  logic [31:0]                now_ms,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [1:0]                 wheel1_dir,
	input  logic [1:0]                 wheel2_dir,
	input  logic [1:0]                 wheel3_dir,
	input  logic [1:0]                 wheel4_dir,
	input  logic                       drive_written,
	input  logic                       step_done,
	input  logic [3:0]                 step_number,
	input  logic [2:0]                 phase_number,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [tmps_pkg::CFG_W-1:0] cfg_data,
	output int                         status_mismatches,
	output int                         status_backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] PHS_LATCH  = 3'd0;
	localparam logic [2:0] PHS_MOVE   = 3'd1;
	localparam logic [2:0] PHS_PAUSE  = 3'd2;
	localparam logic [2:0] PHS_SETTLE = 3'd3;
	localparam logic [2:0] PHS_FINISH = 3'd4;
	localparam int REPORT_MAX = 10;

	localparam logic [8*8-1:0] SQUARE_SEQ = {
		tmps_pkg::MV_ROT, tmps_pkg::MV_LEFT, tmps_pkg::MV_ROT, tmps_pkg::MV_BACK,
		tmps_pkg::MV_ROT, tmps_pkg::MV_RIGHT, tmps_pkg::MV_ROT, tmps_pkg::MV_FWD
	};
	localparam logic [14*8-1:0] HEX_SEQ = {
		tmps_pkg::MV_ROT, tmps_pkg::MV_SW, tmps_pkg::MV_ROT, tmps_pkg::MV_BACK,
		tmps_pkg::MV_ROT, tmps_pkg::MV_SE, tmps_pkg::MV_ROT, tmps_pkg::MV_RIGHT,
		tmps_pkg::MV_ROT, tmps_pkg::MV_NE, tmps_pkg::MV_ROT, tmps_pkg::MV_FWD,
		tmps_pkg::MV_ROT, tmps_pkg::MV_NW
	};

	logic                       pat_sel;
	logic [tmps_pkg::CFG_W-1:0] move_ms;
	logic [tmps_pkg::CFG_W-1:0] pause_ms;
	logic [tmps_pkg::CFG_W-1:0] settle_ms;

	logic [3:0]  step_idx;
	logic [2:0]  phs;
	logic [31:0] start_ms;
	logic [7:0]  drive;

	tmps_pkg::result_t predicted_status[$];

	function automatic tmps_pkg::result_t advance_pattern(input logic o, input logic [31:0] t);
		logic [31:0]       elapsed;
		logic [3:0]        count;
		tmps_pkg::result_t r;
		elapsed = t - start_ms;
		count = (pat_sel == tmps_pkg::PAT_HEXAGON) ? tmps_pkg::HEX_STEPS
			: tmps_pkg::SQUARE_STEPS;
		r.drive_written = 1'b0;
		r.step_done = 1'b0;
		if (o == tmps_pkg::OP_RESTART) begin
			step_idx = 4'd0;
			phs = PHS_LATCH;
			start_ms = '0;
		end else if (step_idx < count) begin
			case (phs)
				PHS_LATCH: begin
					if (pat_sel == tmps_pkg::PAT_HEXAGON)
						drive = HEX_SEQ[int'(step_idx) * 8 +: 8];
					else
						drive = SQUARE_SEQ[int'(step_idx) * 8 +: 8];
					start_ms = t;
					phs = PHS_MOVE;
					r.drive_written = 1'b1;
				end
				PHS_MOVE: begin
					if (elapsed >= {1'b0, move_ms}) begin
						drive = tmps_pkg::MV_OFF;
						start_ms = t;
						phs = PHS_PAUSE;
						r.drive_written = 1'b1;
					end
				end
				PHS_PAUSE: begin
					if (elapsed >= {1'b0, pause_ms}) begin
						start_ms = t;
						phs = PHS_SETTLE;
					end
				end
				PHS_SETTLE: begin
					if (elapsed >= {1'b0, settle_ms})
						phs = PHS_FINISH;
				end
				PHS_FINISH: begin
					phs = PHS_LATCH;
					r.step_done = 1'b1;
					step_idx = (step_idx + 4'd1 >= count) ? 4'd0 : step_idx + 4'd1;
				end
				default: begin
				end
			endcase
		end
		r.drive = drive;
		r.step_number = step_idx;
		r.phase_number = phs;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tmps_pkg::result_t got;
		tmps_pkg::result_t want;
		if (!arst_n) begin
			pat_sel = tmps_pkg::PAT_SQUARE;
			move_ms = '0;
			pause_ms = '0;
			settle_ms = '0;
			step_idx = 4'd0;
			phs = PHS_LATCH;
			start_ms = '0;
			drive = tmps_pkg::MV_OFF;
			predicted_status.delete();
			status_mismatches = 0;
			status_backlog = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.drive = {wheel4_dir, wheel3_dir, wheel2_dir, wheel1_dir};
				got.drive_written = drive_written;
				got.step_done = step_done;
				got.step_number = step_number;
				got.phase_number = phase_number;
				if (predicted_status.size() == 0) begin
					if (status_mismatches < REPORT_MAX)
						$display("%0t: extra result word: drive %h step %0d phase %0d",
							$realtime, got.drive, got.step_number, got.phase_number);
					status_mismatches++;
				end else begin
					want = predicted_status.pop_front();
					if (got !== want) begin
						if (status_mismatches < REPORT_MAX) begin
							$display("%0t: mismatch: expected drive %h written %0d done %0d step %0d phase %0d",
								$realtime, want.drive, want.drive_written, want.step_done,
								want.step_number, want.phase_number);
							$display("%0t: mismatch: got drive %h written %0d done %0d step %0d phase %0d",
								$realtime, got.drive, got.drive_written, got.step_done,
								got.step_number, got.phase_number);
						end
						status_mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					tmps_pkg::REG_PATTERN: pat_sel = cfg_data[0];
					tmps_pkg::REG_MOVE:    move_ms = cfg_data;
					tmps_pkg::REG_PAUSE:   pause_ms = cfg_data;
					tmps_pkg::REG_SETTLE:  settle_ms = cfg_data;
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				predicted_status.push_back(advance_pattern(op, now_ms));
			status_backlog = predicted_status.size();
		end
	end
endmodule

// File: sim/timed_motion_pattern_sequencer_tb.sv
// Testbench top for the motion pattern sequencer: clock, reset, stimulus and verdict.
module timed_motion_pattern_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [tmps_pkg::CFG_W-1:0] cfg_word_t;

	localparam int WATCHDOG = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [tmps_pkg::CFG_W-1:0] TIME_MAX = '1;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       op;
	logic [31:0]                now_ms;
	logic                       out_valid;
	logic                       out_ready;
	logic [1:0]                 wheel1_dir;
	logic [1:0]                 wheel2_dir;
	logic [1:0]                 wheel3_dir;
	logic [1:0]                 wheel4_dir;
	logic                       drive_written;
	logic                       step_done;
	logic [3:0]                 step_number;
	logic [2:0]                 phase_number;
	logic                       cfg_we;
	logic [1:0]                 cfg_index;
	logic [tmps_pkg::CFG_W-1:0] cfg_data;

	int status_mismatches;
	int status_backlog;
	int stall_cycles;

	bit quiet;
	bit hold_off;
	logic [31:0]                clock_ms;
	logic [tmps_pkg::CFG_W-1:0] cur_move;
	logic [tmps_pkg::CFG_W-1:0] cur_pause;
	logic [tmps_pkg::CFG_W-1:0] cur_settle;

	timed_motion_pattern_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wheel1_dir(wheel1_dir),
		.wheel2_dir(wheel2_dir),
		.wheel3_dir(wheel3_dir),
		.wheel4_dir(wheel4_dir),
		.drive_written(drive_written),
		.step_done(step_done),
		.step_number(step_number),
		.phase_number(phase_number),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tmps_status_checker u_status_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wheel1_dir(wheel1_dir),
		.wheel2_dir(wheel2_dir),
		.wheel3_dir(wheel3_dir),
		.wheel4_dir(wheel4_dir),
		.drive_written(drive_written),
		.step_done(step_done),
		.step_number(step_number),
		.phase_number(phase_number),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.status_mismatches(status_mismatches),
		.status_backlog(status_backlog)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_word(input logic o, input logic [31:0] t);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		now_ms <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (status_backlog != 0) @(negedge clk);
	endtask

	task automatic set_config(input logic pat, input logic [tmps_pkg::CFG_W-1:0] mv,
			input logic [tmps_pkg::CFG_W-1:0] ps, input logic [tmps_pkg::CFG_W-1:0] stl);
		cur_move = mv;
		cur_pause = ps;
		cur_settle = stl;
		cfg_we <= 1'b1;
		cfg_index <= tmps_pkg::REG_PATTERN;
		cfg_data <= {{(tmps_pkg::CFG_W-1){1'b0}}, pat};
		@(negedge clk);
		cfg_index <= tmps_pkg::REG_MOVE;
		cfg_data <= mv;
		@(negedge clk);
		cfg_index <= tmps_pkg::REG_PAUSE;
		cfg_data <= ps;
		@(negedge clk);
		cfg_index <= tmps_pkg::REG_SETTLE;
		cfg_data <= stl;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly time advances near the thresholds, some jumps and restarts
	task automatic run_random(input int n);
		int k;
		int sel;
		logic [31:0] base;
		logic [31:0] gap;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				send_word(tmps_pkg::OP_RESTART, $urandom);
			end else begin
				case ($urandom_range(0, 3))
					0: base = {1'b0, cur_move};
					1: base = {1'b0, cur_pause};
					2: base = {1'b0, cur_settle};
					default: base = $urandom_range(0, 16);
				endcase
				case ($urandom_range(0, 7))
					0: gap = '0;
					1: gap = base - 32'd1;
					2: gap = base + 32'd1;
					3: gap = $urandom_range(0, base);
					default: gap = base;
				endcase
				if (sel < 10)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + gap;
				send_word(tmps_pkg::OP_ADVANCE, clock_ms);
			end
		end
	endtask

	initial begin : receiver
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int k;
		in_valid = 1'b0;
		op = tmps_pkg::OP_ADVANCE;
		now_ms = '0;
		cfg_we = 1'b0;
		cfg_index = tmps_pkg::REG_PATTERN;
		cfg_data = '0;
		clock_ms = '0;
		cur_move = '0;
		cur_pause = '0;
		cur_settle = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero times: every advance moves one phase
		set_config(tmps_pkg::PAT_SQUARE, '0, '0, '0);
		send_word(tmps_pkg::OP_ADVANCE, 32'h0000_0000);
		send_word(tmps_pkg::OP_ADVANCE, 32'hFFFF_FFFF);
		send_word(tmps_pkg::OP_ADVANCE, 32'h8000_0000);
		send_word(tmps_pkg::OP_ADVANCE, 32'h0000_0001);
		send_word(tmps_pkg::OP_ADVANCE, 32'h0000_0000);
		send_word(tmps_pkg::OP_ADVANCE, 32'h7FFF_FFFF);
		send_word(tmps_pkg::OP_RESTART, 32'hFFFF_FFFF);
		send_word(tmps_pkg::OP_ADVANCE, 32'h0000_0000);
		drain();

		// longest waits, just below and at the move and pause thresholds, at the settle threshold across the wrap
		set_config(tmps_pkg::PAT_HEXAGON, TIME_MAX, TIME_MAX, TIME_MAX);
		send_word(tmps_pkg::OP_RESTART, 32'h0000_0000);
		send_word(tmps_pkg::OP_ADVANCE, 32'h0000_0000);
		send_word(tmps_pkg::OP_ADVANCE, 32'h7FFF_FFFE);
		send_word(tmps_pkg::OP_ADVANCE, 32'h7FFF_FFFF);
		send_word(tmps_pkg::OP_ADVANCE, 32'hFFFF_FFFD);
		send_word(tmps_pkg::OP_ADVANCE, 32'hFFFF_FFFE);
		send_word(tmps_pkg::OP_ADVANCE, 32'h7FFF_FFFD);
		send_word(tmps_pkg::OP_ADVANCE, 32'h0000_0000);
		send_word(tmps_pkg::OP_ADVANCE, 32'h1234_5678);
		send_word(tmps_pkg::OP_ADVANCE, 32'h1234_5677);
		drain();

		set_config(tmps_pkg::PAT_SQUARE, cfg_word_t'($urandom_range(0, 20)),
			cfg_word_t'($urandom_range(0, 20)), cfg_word_t'($urandom_range(0, 20)));
		hold_off = 1'b1;
		run_random(120);
		drain();

		// run hexagon past step 8, then switch to square so the step holds
		set_config(tmps_pkg::PAT_HEXAGON, '0, '0, '0);
		send_word(tmps_pkg::OP_RESTART, $urandom);
		for (k = 0; k < 115; k++)
			send_word(tmps_pkg::OP_ADVANCE, $urandom);
		drain();
		set_config(tmps_pkg::PAT_SQUARE, cfg_word_t'(5), '0, cfg_word_t'(3));
		for (k = 0; k < 10; k++)
			send_word(tmps_pkg::OP_ADVANCE, $urandom);
		send_word(tmps_pkg::OP_RESTART, $urandom);
		run_random(60);
		drain();

		set_config(tmps_pkg::PAT_HEXAGON, TIME_MAX, TIME_MAX, TIME_MAX);
		run_random(80);
		drain();

		set_config(tmps_pkg::PAT_SQUARE, TIME_MAX, '0, cfg_word_t'(1));
		run_random(60);
		drain();

		set_config(tmps_pkg::PAT_HEXAGON, cfg_word_t'($urandom_range(0, 1000)),
			cfg_word_t'($urandom_range(0, 1000)), cfg_word_t'($urandom_range(0, 1000)));
		quiet = 1'b1;
		run_random(80);
		drain();

		repeat (8) @(negedge clk);
		if (status_mismatches == 0 && status_backlog == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
